/* hdl/torus_vertex_generator_defines.svh */
// Assertion macros shared by the torus vertex generator RTL.
// No dependencies; files that check their own logic include this header.
`ifndef TORUS_VERTEX_GENERATOR_DEFINES_SVH
`define TORUS_VERTEX_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define TVG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");
// Next-cycle implication, checked on every rising edge outside reset.
`define TVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");
`else
`define TVG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TVG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tvg_pkg.sv */
// Shared widths, register codes, latencies and the request type of the torus vertex generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package tvg_pkg;

	// Field widths.
	localparam int IDX_W      = 11;
	localparam int FRAC_W     = 16;
	localparam int TEX_W      = 17;
	localparam int RAD_W      = 16;
	localparam int POS_W      = 25;
	localparam int NRM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register codes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT   = 2'd3;
	localparam logic [RAD_W-1:0]     INNER_RESET      = 16'd256;
	localparam logic [RAD_W-1:0]     OUTER_RESET      = 16'd512;
	localparam int MAX_SEGMENTS_DEF     = 1024;
	localparam int DEFAULT_SEGMENTS_DEF = 30;

	// Divider geometry: the quotient of (index << 16) / count has 17 bits.
	localparam int QBITS   = TEX_W;
	localparam int DIV_W   = IDX_W + FRAC_W;
	localparam int DIV_LAT = QBITS + 1;
	localparam int SC_LAT  = 9;
	localparam int POS_LAT = 3;

	localparam int QUEUE_DEPTH = 4;

	// One classified grid point on its way from the front to the back.
	typedef struct packed {
		logic [IDX_W-1:0] ring_idx;
		logic [IDX_W-1:0] side_idx;
		logic             err;
	} vtx_req_t;

endpackage
`default_nettype wire

/* hdl/torus_vertex_generator.sv */
// Top level of the torus vertex generator: configuration registers, front, queue and back.
// Depends on tvg_pkg, tvg_front, tvg_queue and tvg_back.
//
// Each accepted (ring_index, side_index) transaction yields one vertex: position in Q10.14,
// normal in Q1.15 and texture coordinates in Q1.16, with index_error and zeros for a point
// outside the configured counts, or for every point under a zero or oversized count. The block
// takes one transaction per clock and delivers one vertex per clock while nothing stalls. A
// vertex passes the input register, the queue, the pipelined phase divider (a load stage and
// one quotient bit per stage), the sine/cosine pipeline and the vertex multiplies, whose last
// stage feeds the output register. A four-entry queue lets the input keep flowing for a few
// transactions while the output is stalled. Configuration writes must only be made while no
// vertex is in flight.
`default_nettype none
module torus_vertex_generator
	import tvg_pkg::*;
#(
	parameter int MAX_SEGMENTS     = MAX_SEGMENTS_DEF,
	parameter int DEFAULT_SEGMENTS = DEFAULT_SEGMENTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [IDX_W-1:0]      ring_index,
	input  wire logic [IDX_W-1:0]      side_index,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [POS_W-1:0]    pos_x,
	output logic signed [POS_W-1:0]    pos_y,
	output logic signed [POS_W-1:0]    pos_z,
	output logic signed [NRM_W-1:0]    normal_x,
	output logic signed [NRM_W-1:0]    normal_y,
	output logic signed [NRM_W-1:0]    normal_z,
	output logic [TEX_W-1:0]           tex_u,
	output logic [TEX_W-1:0]           tex_v,
	output logic                       index_error
);

	logic [RAD_W-1:0] inner_radius_q;
	logic [RAD_W-1:0] outer_radius_q;
	logic [IDX_W-1:0] side_count_q;
	logic [IDX_W-1:0] ring_count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_radius_q <= INNER_RESET;
			outer_radius_q <= OUTER_RESET;
			side_count_q   <= IDX_W'(DEFAULT_SEGMENTS);
			ring_count_q   <= IDX_W'(DEFAULT_SEGMENTS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INNER_RADIUS: inner_radius_q <= cfg_data;
				REG_OUTER_RADIUS: outer_radius_q <= cfg_data;
				REG_SIDE_COUNT:   side_count_q   <= cfg_data[IDX_W-1:0];
				REG_RING_COUNT:   ring_count_q   <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	vtx_req_t front_item;
	vtx_req_t queue_head;
	logic     push;
	logic     pop;
	logic     queue_full;
	logic     queue_not_empty;

	// Accept and classify.
	tvg_front #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ring_index (ring_index),
		.side_index (side_index),
		.side_count (side_count_q),
		.ring_count (ring_count_q),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	// Decoupling queue.
	tvg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (front_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.head      (queue_head)
	);

	// Vertex computation.
	tvg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (queue_head),
		.head_valid   (queue_not_empty),
		.pop          (pop),
		.side_count   (side_count_q),
		.ring_count   (ring_count_q),
		.inner_radius (inner_radius_q),
		.outer_radius (outer_radius_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.index_error  (index_error)
	);

endmodule
`default_nettype wire

/* hdl/tvg_front.sv */
// Input side: takes grid point transactions, range-checks them and hands them to the queue.
// Depends on tvg_pkg.
`default_nettype none
module tvg_front
	import tvg_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [IDX_W-1:0] ring_index,
	input  wire logic [IDX_W-1:0] side_index,
	input  wire logic [IDX_W-1:0] side_count,
	input  wire logic [IDX_W-1:0] ring_count,
	input  wire logic             queue_full,
	output logic                  push,
	output vtx_req_t              item
);

	logic     hold_q;
	vtx_req_t item_q;
	logic     accept;
	logic     bad_cfg;

	assign push     = hold_q && !queue_full;
	assign in_stall = hold_q && queue_full;
	assign accept   = in_valid && !in_stall;
	assign item     = item_q;

	// A count of zero or above the supported maximum rejects every point.
	assign bad_cfg = (side_count == '0) || (ring_count == '0) ||
		(int'(side_count) > MAX_SEGMENTS) || (int'(ring_count) > MAX_SEGMENTS);

	// Holding register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (accept) begin
			hold_q <= 1'b1;
		end else if (push) begin
			hold_q <= 1'b0;
		end
	end

	// Capture and classify the transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.ring_idx <= ring_index;
			item_q.side_idx <= side_index;
			item_q.err      <= bad_cfg || (ring_index > ring_count) ||
				(side_index > side_count);
		end
	end

endmodule
`default_nettype wire

/* hdl/tvg_queue.sv */
// Short request queue between the front and the back, so each side can stall on its own.
// Depends on tvg_pkg and the assertion macro header.
`default_nettype none
`include "torus_vertex_generator_defines.svh"
module tvg_queue
	import tvg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  vtx_req_t  wr_item,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output vtx_req_t  head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	vtx_req_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	`TVG_ASSERT_IMPL(a_no_push_when_full, clk, arst_n, push, !full)
	`TVG_ASSERT_IMPL(a_no_pop_when_empty, clk, arst_n, pop, not_empty)

endmodule
`default_nettype wire

/* hdl/tvg_divider.sv */
// Pipelined restoring divider giving floor((index << 16) / count), one quotient bit per stage.
// Depends on tvg_pkg.
`default_nettype none
module tvg_divider
	import tvg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [IDX_W-1:0] index,
	input  wire logic [IDX_W-1:0] count,
	output logic [QBITS-1:0]      quot
);

	logic [DIV_W-1:0] rem_s [QBITS];
	logic [IDX_W-1:0] den_s [QBITS];
	logic [QBITS-1:0] quo_s [QBITS+1];

	// Load stage: the dividend is the index scaled by 2^16.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {index, {FRAC_W{1'b0}}};
			den_s[0] <= count;
			quo_s[0] <= '0;
		end
	end

	// One compare and subtract per stage, most significant quotient bit first.
	for (genvar k = 0; k < QBITS; k++) begin : g_stage
		localparam int B = QBITS - 1 - k;
		localparam logic [QBITS-1:0] QBIT = {{(QBITS-1){1'b0}}, 1'b1} << B;
		logic [DIV_W-1:0] sub;
		logic             ge;

		assign sub = DIV_W'(den_s[k]) << B;
		assign ge  = rem_s[k] >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= ge ? (quo_s[k] | QBIT) : quo_s[k];
			end
		end

		if (k < QBITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? (rem_s[k] - sub) : rem_s[k];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign quot = quo_s[QBITS];

endmodule
`default_nettype wire

/* hdl/tvg_sincos.sv */
// Nine-stage pipelined sine and cosine of a 16-bit turn fraction, Q1.15 results.
// Octant folding and truncated Taylor polynomials in Q2.30; depends on tvg_pkg.
`default_nettype none
module tvg_sincos
	import tvg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [FRAC_W-1:0] phase,
	output logic signed [NRM_W-1:0] sin_val,
	output logic signed [NRM_W-1:0] cos_val
);

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [33:0] RAD_SCALE = 34'd411775;
	// Exact reciprocals: ceil(2^(31+l)/d) with 2^(l-1) < d <= 2^l.
	localparam logic [32:0] RCP_42 = 33'(((64'd1 << 37) + 64'd41) / 64'd42);
	localparam logic [32:0] RCP_56 = 33'(((64'd1 << 37) + 64'd55) / 64'd56);
	localparam logic [32:0] RCP_20 = 33'(((64'd1 << 36) + 64'd19) / 64'd20);
	localparam logic [32:0] RCP_30 = 33'(((64'd1 << 36) + 64'd29) / 64'd30);
	localparam logic [32:0] RCP_6  = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
	localparam logic [32:0] RCP_12 = 33'(((64'd1 << 35) + 64'd11) / 64'd12);

	function automatic logic signed [NRM_W-1:0] q30_to_q15(input logic [30:0] v);
		logic [16:0] r;
		r = 17'((32'(v) + 32'd16384) >> 15);
		return (r > 17'd32767) ? 16'sd32767 : $signed(r[15:0]);
	endfunction

	function automatic logic oct_sel(input logic [2:0] o);
		return o[0];
	endfunction

	logic [2:0]  oct_s1, oct_s2, oct_s3, oct_s4, oct_s5, oct_s6, oct_s7, oct_s8;
	logic [29:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic [29:0] x2_s2, x2_s3, x2_s4, x2_s5, x2_s6, x2_s7;
	logic [29:0] qs_s3, qc_s3, ps_s4, pc_s4, qs_s5, qc_s5;
	logic [29:0] ps_s6, pc_s6, qs_s7, qc_s7, ps_s8, pc_s8;
	logic signed [NRM_W-1:0] sin_s9, cos_s9;

	logic [13:0] ang;
	logic [33:0] xprod;
	logic [59:0] xsq;
	logic [62:0] m3s, m3c, m5s, m5c, m7s, m7c;
	logic [30:0] t4s, t4c, t6s, t6c, t8s, t8c, cq;
	logic [60:0] p4s, p4c, p6s, p6c, p8s, p8c;
	logic signed [NRM_W-1:0] sa, ca, s0, c0;

	// Stage 1: fold into the first octant and scale to Q2.30 radians.
	assign ang   = oct_sel(phase[15:13]) ? (14'd8192 - {1'b0, phase[12:0]})
		: {1'b0, phase[12:0]};
	assign xprod = 34'(ang) * RAD_SCALE + 34'd2;

	always_ff @(posedge clk) begin
		if (en) begin
			oct_s1 <= phase[15:13];
			x_s1   <= xprod[31:2];
		end
	end

	// Stage 2: square.
	assign xsq = 60'(x_s1) * 60'(x_s1);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s2 <= oct_s1;
			x_s2   <= x_s1;
			x2_s2  <= xsq[59:30];
		end
	end

	// Stage 3: innermost Horner divisions.
	assign m3s = 63'(x2_s2) * 63'(RCP_42);
	assign m3c = 63'(x2_s2) * 63'(RCP_56);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s3 <= oct_s2;
			x_s3   <= x_s2;
			x2_s3  <= x2_s2;
			qs_s3  <= 30'(m3s >> 37);
			qc_s3  <= 30'(m3c >> 37);
		end
	end

	// Stage 4: first Horner products.
	assign t4s = ONE_Q30 - {1'b0, qs_s3};
	assign t4c = ONE_Q30 - {1'b0, qc_s3};
	assign p4s = 61'(x2_s3) * 61'(t4s);
	assign p4c = 61'(x2_s3) * 61'(t4c);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s4 <= oct_s3;
			x_s4   <= x_s3;
			x2_s4  <= x2_s3;
			ps_s4  <= p4s[59:30];
			pc_s4  <= p4c[59:30];
		end
	end

	// Stage 5: middle divisions.
	assign m5s = 63'(ps_s4) * 63'(RCP_20);
	assign m5c = 63'(pc_s4) * 63'(RCP_30);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s5 <= oct_s4;
			x_s5   <= x_s4;
			x2_s5  <= x2_s4;
			qs_s5  <= 30'(m5s >> 36);
			qc_s5  <= 30'(m5c >> 36);
		end
	end

	// Stage 6: second Horner products.
	assign t6s = ONE_Q30 - {1'b0, qs_s5};
	assign t6c = ONE_Q30 - {1'b0, qc_s5};
	assign p6s = 61'(x2_s5) * 61'(t6s);
	assign p6c = 61'(x2_s5) * 61'(t6c);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s6 <= oct_s5;
			x_s6   <= x_s5;
			x2_s6  <= x2_s5;
			ps_s6  <= p6s[59:30];
			pc_s6  <= p6c[59:30];
		end
	end

	// Stage 7: outer divisions.
	assign m7s = 63'(ps_s6) * 63'(RCP_6);
	assign m7c = 63'(pc_s6) * 63'(RCP_12);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s7 <= oct_s6;
			x_s7   <= x_s6;
			x2_s7  <= x2_s6;
			qs_s7  <= 30'(m7s >> 34);
			qc_s7  <= 30'(m7c >> 35);
		end
	end

	// Stage 8: sine times x, cosine times x squared.
	assign t8s = ONE_Q30 - {1'b0, qs_s7};
	assign t8c = ONE_Q30 - {1'b0, qc_s7};
	assign p8s = 61'(x_s7) * 61'(t8s);
	assign p8c = 61'(x2_s7) * 61'(t8c);
	always_ff @(posedge clk) begin
		if (en) begin
			oct_s8 <= oct_s7;
			ps_s8  <= p8s[59:30];
			pc_s8  <= p8c[59:30];
		end
	end

	// Stage 9: convert to Q1.15 and unfold the octant.
	assign cq = ONE_Q30 - {2'b00, pc_s8[29:1]};
	assign sa = q30_to_q15({1'b0, ps_s8});
	assign ca = q30_to_q15(cq);
	assign s0 = oct_s8[0] ? ca : sa;
	assign c0 = oct_s8[0] ? sa : ca;

	always_ff @(posedge clk) begin
		if (en) begin
			case (oct_s8[2:1])
				2'd0: begin
					sin_s9 <= s0;
					cos_s9 <= c0;
				end
				2'd1: begin
					sin_s9 <= c0;
					cos_s9 <= -s0;
				end
				2'd2: begin
					sin_s9 <= -s0;
					cos_s9 <= -c0;
				end
				default: begin
					sin_s9 <= -c0;
					cos_s9 <= s0;
				end
			endcase
		end
	end

	assign sin_val = sin_s9;
	assign cos_val = cos_s9;

endmodule
`default_nettype wire

/* hdl/tvg_back.sv */
// Execution side: phase division, sine and cosine, vertex arithmetic and the output register.
// Depends on tvg_pkg, tvg_divider, tvg_sincos and the assertion macro header.
`default_nettype none
`include "torus_vertex_generator_defines.svh"
module tvg_back
	import tvg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  vtx_req_t                head,
	input  wire logic               head_valid,
	output logic                    pop,
	input  wire logic [IDX_W-1:0]   side_count,
	input  wire logic [IDX_W-1:0]   ring_count,
	input  wire logic [RAD_W-1:0]   inner_radius,
	input  wire logic [RAD_W-1:0]   outer_radius,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic [TEX_W-1:0]        tex_u,
	output logic [TEX_W-1:0]        tex_v,
	output logic                    index_error
);

	localparam int TOTAL   = DIV_LAT + SC_LAT + POS_LAT;
	localparam int TEX_DLY = SC_LAT + POS_LAT - 1;

	// Round half away from zero by a right shift of s bits.
	function automatic logic signed [63:0] round_sh(input logic signed [63:0] v,
		input int s);
		logic signed [63:0] half;
		logic signed [63:0] mag;
		logic signed [63:0] r;
		half = 64'sd1 <<< (s - 1);
		mag  = (v < 0) ? -v : v;
		r    = (mag + half) >>> s;
		return (v < 0) ? -r : r;
	endfunction

	function automatic logic signed [NRM_W-1:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sd32767;
		end
		if (v < -64'sd32768) begin
			return -16'sd32768;
		end
		return 16'(v);
	endfunction

	logic             adv;
	logic [TOTAL-1:0] vld_q;
	logic [TOTAL-1:0] err_q;
	logic [TEX_W-1:0] fu, fv;
	logic [TEX_W-1:0] texu_q [TEX_DLY];
	logic [TEX_W-1:0] texv_q [TEX_DLY];
	logic signed [NRM_W-1:0] sphi, cphi, sth, cth;

	// The whole back end moves together unless a finished vertex is held.
	assign adv       = !vld_q[TOTAL-1] || !out_stall;
	assign pop       = adv && head_valid;
	assign out_valid = vld_q[TOTAL-1];

	// Occupancy tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOTAL-2:0], head_valid};
		end
	end

	// Rejection flag travels beside the data.
	always_ff @(posedge clk) begin
		if (adv) begin
			err_q <= {err_q[TOTAL-2:0], head.err};
		end
	end

	// Phase fractions.
	tvg_divider u_div_u (
		.clk   (clk),
		.en    (adv),
		.index (head.side_idx),
		.count (side_count),
		.quot  (fu)
	);

	tvg_divider u_div_v (
		.clk   (clk),
		.en    (adv),
		.index (head.ring_idx),
		.count (ring_count),
		.quot  (fv)
	);

	// Texture coordinates wait for the geometry.
	always_ff @(posedge clk) begin
		if (adv) begin
			texu_q[0] <= fu;
			texv_q[0] <= fv;
			for (int k = 1; k < TEX_DLY; k++) begin
				texu_q[k] <= texu_q[k-1];
				texv_q[k] <= texv_q[k-1];
			end
		end
	end

	// Tube angle and ring angle.
	tvg_sincos u_sc_phi (
		.clk     (clk),
		.en      (adv),
		.phase   (fu[FRAC_W-1:0]),
		.sin_val (sphi),
		.cos_val (cphi)
	);

	tvg_sincos u_sc_theta (
		.clk     (clk),
		.en      (adv),
		.phase   (fv[FRAC_W-1:0]),
		.sin_val (sth),
		.cos_val (cth)
	);

	// Position stage 1: radius products and normal products.
	logic signed [32:0]      rc_s1, zp_s1;
	logic signed [31:0]      nx_s1, ny_s1;
	logic signed [NRM_W-1:0] sphi_s1, cth_s1, sth_s1;
	logic signed [16:0]      r_sgn;

	assign r_sgn = $signed({1'b0, inner_radius});

	always_ff @(posedge clk) begin
		if (adv) begin
			rc_s1   <= 33'(r_sgn) * 33'(cphi);
			zp_s1   <= 33'(r_sgn) * 33'(sphi);
			nx_s1   <= 32'(cphi) * 32'(cth);
			ny_s1   <= 32'(cphi) * 32'(sth);
			sphi_s1 <= sphi;
			cth_s1  <= cth;
			sth_s1  <= sth;
		end
	end

	// Position stage 2: ring distance times ring angle; z and normals rounded.
	logic signed [33:0]      m_sum;
	logic signed [49:0]      mx_s2, my_s2;
	logic signed [POS_W-1:0] pz_s2;
	logic signed [NRM_W-1:0] nx_s2, ny_s2, nz_s2;

	assign m_sum = (34'($signed({1'b0, outer_radius})) <<< 15) + 34'(rc_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2 <= 50'(m_sum) * 50'(cth_s1);
			my_s2 <= 50'(m_sum) * 50'(sth_s1);
			pz_s2 <= POS_W'(round_sh(64'(zp_s1), 9));
			nx_s2 <= sat16(round_sh(64'(nx_s1), 15));
			ny_s2 <= sat16(round_sh(64'(ny_s1), 15));
			nz_s2 <= sphi_s1;
		end
	end

	// Output register; a rejected point gives all zeros.
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [NRM_W-1:0] nrm_x_q, nrm_y_q, nrm_z_q;
	logic [TEX_W-1:0]        tex_u_q, tex_v_q;
	logic                    rej;

	assign rej = err_q[TOTAL-2];

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x_q <= rej ? '0 : POS_W'(round_sh(64'(mx_s2), 24));
			pos_y_q <= rej ? '0 : POS_W'(round_sh(64'(my_s2), 24));
			pos_z_q <= rej ? '0 : pz_s2;
			nrm_x_q <= rej ? '0 : nx_s2;
			nrm_y_q <= rej ? '0 : ny_s2;
			nrm_z_q <= rej ? '0 : nz_s2;
			tex_u_q <= rej ? '0 : texu_q[TEX_DLY-1];
			tex_v_q <= rej ? '0 : texv_q[TEX_DLY-1];
		end
	end

	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign pos_z       = pos_z_q;
	assign normal_x    = nrm_x_q;
	assign normal_y    = nrm_y_q;
	assign normal_z    = nrm_z_q;
	assign tex_u       = tex_u_q;
	assign tex_v       = tex_v_q;
	assign index_error = err_q[TOTAL-1];

	`TVG_ASSERT_IMPL(a_tex_in_range, clk, arst_n, out_valid && !index_error, (tex_u <= 17'd65536) && (tex_v <= 17'd65536))
	`TVG_ASSERT_NEXT(a_pop_fills_entry, clk, arst_n, pop, vld_q[0])

endmodule
`default_nettype wire

/* tb/sv/torus_vertex_generator_tb.sv */
// Self-checking testbench for the torus vertex generator: directed and random grid points.
// Depends on tvg_pkg and torus_vertex_generator; a local model predicts every vertex.
`default_nettype none
module torus_vertex_generator_tb;
	import tvg_pkg::*;

	// Expected vertex fields, in port order.
	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic [TEX_W-1:0]        tu;
		logic [TEX_W-1:0]        tv;
		logic                    err;
	} vertex_t;

	typedef struct packed {
		logic [IDX_W-1:0] ring;
		logic [IDX_W-1:0] side;
	} point_t;

	localparam int LATENCY = 31;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_LEN = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [IDX_W-1:0]      ring_index;
	logic [IDX_W-1:0]      side_index;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic [TEX_W-1:0]      tex_u, tex_v;
	logic                  index_error;

	torus_vertex_generator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.ring_index(ring_index), .side_index(side_index), .out_valid(out_valid),
		.out_stall(out_stall), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.tex_u(tex_u), .tex_v(tex_v), .index_error(index_error)
	);

	// Model copy of the configuration registers.
	longint unsigned tube_r, ring_r, sides, rings;

	point_t  pending_points[$];
	vertex_t expected_vertices[$];
	int      mismatch_count;
	int      idle_cycles;
	bit      quiet_phase;
	bit      hold_output;
	int      hold_cycles;
	int      hold_req;
	int      hold_seen;
	int      in_gap;
	int      out_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_half_away(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) begin
			return (v + half) >>> s;
		end
		return -(((-v) + half) >>> s);
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) begin
			return 32767;
		end
		if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	function automatic longint q30_to_q15(longint unsigned v);
		longint unsigned r;
		r = (v + (64'd1 << 14)) >> 15;
		return (r > 32767) ? 32767 : longint'(r);
	endfunction

	// Sine and cosine of a first-octant angle a/65536 turn via Taylor polynomials.
	function automatic void octant_trig(input longint unsigned a, output longint s,
		output longint c);
		longint unsigned x, x2, t, one;
		one = 64'd1 << 30;
		x = (a * 411775 + 2) >> 2;
		x2 = (x * x) >> 30;
		t = one - x2 / 42;
		t = one - ((x2 * t) >> 30) / 20;
		t = one - ((x2 * t) >> 30) / 6;
		s = q30_to_q15((x * t) >> 30);
		t = one - x2 / 56;
		t = one - ((x2 * t) >> 30) / 30;
		t = one - ((x2 * t) >> 30) / 12;
		c = q30_to_q15(one - ((x2 * t) >> 30) / 2);
	endfunction

	// Full-turn sine and cosine by octant folding.
	function automatic void turn_trig(input longint unsigned frac, output longint s,
		output longint c);
		longint unsigned f, oct, r;
		longint sa, ca, s0, c0;
		f = frac & 64'hFFFF;
		oct = f >> 13;
		r = f & 64'h1FFF;
		if (oct[0]) begin
			octant_trig(8192 - r, sa, ca);
			s0 = ca;
			c0 = sa;
		end else begin
			octant_trig(r, sa, ca);
			s0 = sa;
			c0 = ca;
		end
		case (oct >> 1)
			0: begin s = s0;  c = c0;  end
			1: begin s = c0;  c = -s0; end
			2: begin s = -s0; c = -c0; end
			default: begin s = -c0; c = s0; end
		endcase
	endfunction

	function automatic vertex_t torus_vertex(point_t p);
		vertex_t v;
		longint unsigned i, j, fu, fv;
		longint sphi, cphi, sth, cth, m;
		v = '0;
		i = p.ring;
		j = p.side;
		if (sides == 0 || rings == 0 || sides > 1024 || rings > 1024 ||
				i > rings || j > sides) begin
			v.err = 1'b1;
			return v;
		end
		fu = (j << 16) / sides;
		fv = (i << 16) / rings;
		turn_trig(fu, sphi, cphi);
		turn_trig(fv, sth, cth);
		m = (longint'(ring_r) << 15) + longint'(tube_r) * cphi;
		v.px = POS_W'(round_half_away(m * cth, 24));
		v.py = POS_W'(round_half_away(m * sth, 24));
		v.pz = POS_W'(round_half_away(longint'(tube_r) * sphi, 9));
		v.nx = NRM_W'(clamp16(round_half_away(cphi * cth, 15)));
		v.ny = NRM_W'(clamp16(round_half_away(cphi * sth, 15)));
		v.nz = NRM_W'(clamp16(sphi));
		v.tu = TEX_W'(fu);
		v.tv = TEX_W'(fv);
		return v;
	endfunction

	// Driver: present the next pending point, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
			ring_index <= '0;
			side_index <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_vertices.insert(expected_vertices.size(),
					torus_vertex({ring_index, side_index}));
				void'(pending_points.pop_front());
			end
			if (in_valid && in_stall) begin
				// Hold the stalled transaction.
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
				in_gap <= $urandom_range(0, 13);
				in_valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				point_t nxt;
				nxt = pending_points[0];
				in_valid <= 1'b1;
				ring_index <= nxt.ring;
				side_index <= nxt.side;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: random bursts, plus one long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else if (hold_output) begin
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
			out_gap <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: compare each delivered vertex with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			vertex_t got, exp_v;
			got = {pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, index_error};
			if (expected_vertices.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected vertex: %p", got);
				end
			end else begin
				exp_v = expected_vertices.pop_front();
				if (got !== exp_v) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Vertex mismatch: expected %p actual %p", exp_v, got);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_output ||
				(pending_points.size() == 0 && expected_vertices.size() == 0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Long receiver hold-off, counted in its own process.
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_cycles <= HOLD_LEN;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	assign hold_output = (hold_cycles > 0);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (idx)
			REG_INNER_RADIUS: tube_r = value & 16'hFFFF;
			REG_OUTER_RADIUS: ring_r = value & 16'hFFFF;
			REG_SIDE_COUNT:   sides = value & 11'h7FF;
			default:          rings = value & 11'h7FF;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_points.size() != 0 || in_valid || expected_vertices.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic queue_point(input int r, input int s);
		point_t p;
		p.ring = IDX_W'(r);
		p.side = IDX_W'(s);
		pending_points.insert(pending_points.size(), p);
	endtask

	// Mostly in-range points, some one past the count, some fully random.
	task automatic queue_random(input int n);
		int k, sel;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				queue_point($urandom_range(0, int'(rings)), $urandom_range(0, int'(sides)));
			end else if (sel < 8) begin
				queue_point(int'(rings) + 1, $urandom_range(0, 2047));
			end else begin
				queue_point($urandom_range(0, 2047), $urandom_range(0, 2047));
			end
		end
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INNER_RADIUS;
		cfg_data = '0;
		quiet_phase = 1'b0;
		tube_r = INNER_RESET;
		ring_r = OUTER_RESET;
		sides = DEFAULT_SEGMENTS_DEF;
		rings = DEFAULT_SEGMENTS_DEF;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners, full turns, octant boundaries and out-of-range points.
		queue_point(0, 0);
		queue_point(30, 30);
		queue_point(30, 0);
		queue_point(0, 30);
		queue_point(31, 0);
		queue_point(0, 31);
		queue_point(2047, 2047);
		queue_point(15, 15);
		queue_point(7, 22);
		queue_point(1024, 0);
		drain();

		// Largest counts and radii with a long hold-off at the output.
		write_reg(REG_INNER_RADIUS, 16'hFFFF);
		write_reg(REG_OUTER_RADIUS, 16'hFFFF);
		write_reg(REG_SIDE_COUNT, 1024);
		write_reg(REG_RING_COUNT, 1024);
		queue_point(1024, 1024);
		queue_point(512, 256);
		queue_point(1025, 0);
		queue_point(1023, 1);
		hold_req = hold_req + 1;
		queue_random(60);
		drain();

		// Bad counts: zero and above the maximum.
		write_reg(REG_SIDE_COUNT, 0);
		write_reg(REG_RING_COUNT, 2047);
		queue_point(0, 0);
		queue_point(1, 1);
		drain();

		// Random settings, extremes among them.
		for (ph = 0; ph < 8; ph++) begin
			write_reg(REG_INNER_RADIUS, (ph == 0) ? 0 : $urandom_range(0, 65535));
			write_reg(REG_OUTER_RADIUS, (ph == 1) ? 0 : $urandom_range(0, 65535));
			write_reg(REG_SIDE_COUNT, (ph == 2) ? 1 : $urandom_range(1, 1024));
			write_reg(REG_RING_COUNT, (ph == 3) ? 1 : $urandom_range(1, 1024));
			if (ph == 7) begin
				quiet_phase = 1'b1;
			end
			queue_random(210);
			drain();
		end

		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
